// File: sv/windowed_posting_union_assert.svh
// assertion macros shared by the windowed posting union modules
// no dependencies; included by files that carry concurrent checks
`ifndef WINDOWED_POSTING_UNION_ASSERT_SVH
`define WINDOWED_POSTING_UNION_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define WPU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant, same clocking
`define WPU_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// File: sv/wpu_pkg.sv
// types and constants of the windowed posting union
// no dependencies; imported by wpu_ctrl, wpu_dp and the top module
package wpu_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  localparam logic [1:0] CMD_OPEN = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;
  localparam logic [1:0] CMD_SKIP = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] doc_id;
    logic [23:0] term_score;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] doc_out;
    logic [31:0] score_out;
    logic        out_of_window;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_OPEN,
    DP_EMIT_ZERO,
    DP_EMIT_OOW,
    DP_ADD_RD,
    DP_ADD_WR,
    DP_SCAN_RD,
    DP_SCAN_ADV,
    DP_TAKE_RD,
    DP_TAKE_OUT,
    DP_SKIP_ALL,
    DP_SKIP_RD,
    DP_SKIP_WR
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       add_oow;
    logic       skip_noop;
    logic       skip_beyond;
    logic       scan_end;
    logic       word_zero;
  } dp_status_t;

endpackage

// File: sv/wpu_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/wpu_ctrl.sv
// sequencer of the windowed posting union
// depends on wpu_pkg and the assertion macro header
`include "windowed_posting_union_assert.svh"
module wpu_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wpu_pkg::dp_status_t status,
  output wpu_pkg::dp_cmd_t    cmd
);
  import wpu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_ADD_WR,
    S_SKIP_WR,
    S_SCAN_CHK,
    S_SCAN_TEST,
    S_TAKE_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = DP_NOP;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = S_DISP;
      end
      S_DISP: begin
        case (status.command)
          CMD_OPEN: begin
            cmd.op    = DP_OPEN;
            state_nxt = S_IDLE;
          end
          CMD_ADD: begin
            if (status.add_oow) begin
              cmd.op    = DP_EMIT_OOW;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = DP_ADD_RD;
              state_nxt = S_ADD_WR;
            end
          end
          CMD_NEXT: begin
            if (status.scan_end) begin
              cmd.op    = DP_EMIT_ZERO;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = DP_SCAN_RD;
              state_nxt = S_SCAN_CHK;
            end
          end
          default: begin
            if (status.skip_noop) begin
              cmd.op    = DP_EMIT_ZERO;
              state_nxt = S_IDLE;
            end else if (status.skip_beyond) begin
              cmd.op    = DP_SKIP_ALL;
              state_nxt = S_IDLE;
            end else begin
              cmd.op    = DP_SKIP_RD;
              state_nxt = S_SKIP_WR;
            end
          end
        endcase
      end
      S_ADD_WR: begin
        cmd.op    = DP_ADD_WR;
        state_nxt = S_IDLE;
      end
      S_SKIP_WR: begin
        cmd.op    = DP_SKIP_WR;
        state_nxt = S_IDLE;
      end
      S_SCAN_CHK: begin
        if (status.word_zero) begin
          cmd.op    = DP_SCAN_ADV;
          state_nxt = S_SCAN_TEST;
        end else begin
          cmd.op    = DP_TAKE_RD;
          state_nxt = S_TAKE_OUT;
        end
      end
      S_SCAN_TEST: begin
        if (status.scan_end) begin
          cmd.op    = DP_EMIT_ZERO;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = DP_SCAN_RD;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_TAKE_OUT: begin
        cmd.op    = DP_TAKE_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  `WPU_ASSERT(a_accept_busy, clk, rst_n, (start && !busy_r) |=> busy_r, "accept did not raise busy")
  `WPU_ASSERT(a_load_idle, clk, rst_n, cmd.load |-> !busy_r, "item loaded while busy")
  `WPU_ASSERT(a_take_done, clk, rst_n, (cmd.op == DP_TAKE_OUT) |=> !busy_r, "busy after next result")

endmodule

// File: sv/wpu_dp.sv
// datapath: window state, bitmap and accumulator rams, result register
// depends on wpu_pkg, wpu_ram and the assertion macro header
`include "windowed_posting_union_assert.svh"
module wpu_dp #(
  parameter int WINDOW_WORDS = 64,
  parameter int SCORE_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wpu_pkg::in_item_t   in_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  wpu_pkg::dp_cmd_t    cmd,
  output wpu_pkg::dp_status_t status,
  output logic                out_strobe,
  output wpu_pkg::out_item_t  out_item
);
  import wpu_pkg::*;

  localparam int SLOTS  = WINDOW_WORDS * WORD_BITS;
  localparam int WIDX_W = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
  localparam int SCAN_W = $clog2(WINDOW_WORDS + 1);
  localparam int ACC_AW = $clog2(SLOTS);
  localparam int EW     = ((SCORE_BITS > 24) ? SCORE_BITS : 24) + 1;

  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] n;
    n = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) n = BIT_W'(i);
    end
    return n;
  endfunction

  // latched item and window state
  logic [1:0]        command_r;
  logic [31:0]       doc_r;
  logic [23:0]       score_r;
  logic [31:0]       base_r, base_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic [WINDOW_WORDS-1:0] wvalid_r, wvalid_nxt;
  logic              en_r;
  logic              rd_valid_r, rd_valid_nxt;
  logic [ACC_AW-1:0] slot_r;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_r, out_nxt;

  logic [31:0]          delta;
  logic [WIDX_W-1:0]    delta_word;
  logic [BIT_W-1:0]     delta_bit;
  logic [ACC_AW-1:0]    delta_slot;
  logic [WIDX_W-1:0]    scan_idx;
  logic [SCAN_W-1:0]    delta_word_ext;
  logic [WORD_BITS-1:0] word_eff;
  logic [BIT_W-1:0]     take_bit;
  logic [WIDX_W+BIT_W-1:0] take_full;
  logic [ACC_AW-1:0]    take_slot;
  logic                 bit_set;

  logic                 bm_we, bm_re;
  logic [WIDX_W-1:0]    bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic                 acc_we, acc_re;
  logic [ACC_AW-1:0]    acc_waddr, acc_raddr;
  logic [SCORE_BITS-1:0] acc_wdata, acc_rdata, acc_base, acc_sat;
  logic [EW-1:0]        sum, acc_max_ext;
  logic [31:0]          score_clip;

  assign delta          = doc_r - base_r;
  assign delta_word     = delta[WIDX_W+BIT_W-1:BIT_W];
  assign delta_bit      = delta[BIT_W-1:0];
  assign delta_slot     = delta[ACC_AW-1:0];
  assign scan_idx       = scan_r[WIDX_W-1:0];
  assign delta_word_ext = SCAN_W'(delta_word);
  assign word_eff       = rd_valid_r ? bm_rdata : '0;
  assign take_bit       = low_bit(word_eff);
  assign take_full      = {scan_idx, take_bit};
  assign take_slot      = take_full[ACC_AW-1:0];
  assign bit_set        = word_eff[delta_bit];

  assign status.command     = command_r;
  assign status.add_oow     = (delta >= 32'(SLOTS)) ||
                              (delta[31:BIT_W] < (32-BIT_W)'(scan_r));
  assign status.skip_noop   = !(doc_r > base_r);
  assign status.skip_beyond = (delta >= 32'(SLOTS));
  assign status.scan_end    = (scan_r == SCAN_W'(WINDOW_WORDS));
  assign status.word_zero   = (word_eff == '0);

  // saturating accumulate; a clear slot always reads as zero
  assign acc_base    = bit_set ? acc_rdata : '0;
  assign sum         = EW'(acc_base) + EW'(score_r);
  assign acc_max_ext = EW'({SCORE_BITS{1'b1}});
  assign acc_sat     = (sum > acc_max_ext) ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];

  generate
    if (SCORE_BITS > 32) begin : g_clip
      assign score_clip = (|acc_rdata[SCORE_BITS-1:32]) ? 32'hFFFF_FFFF : acc_rdata[31:0];
    end else if (SCORE_BITS == 32) begin : g_same
      assign score_clip = acc_rdata;
    end else begin : g_ext
      assign score_clip = {{(32-SCORE_BITS){1'b0}}, acc_rdata};
    end
  endgenerate

  always_comb begin
    base_nxt       = base_r;
    scan_nxt       = scan_r;
    wvalid_nxt     = wvalid_r;
    rd_valid_nxt   = rd_valid_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    bm_we = 1'b0; bm_re = 1'b0;
    bm_waddr = delta_word; bm_raddr = delta_word; bm_wdata = word_eff;
    acc_we = 1'b0; acc_re = 1'b0;
    acc_waddr = delta_slot; acc_raddr = delta_slot; acc_wdata = acc_sat;
    case (cmd.op)
      DP_OPEN: begin
        base_nxt       = doc_r;
        scan_nxt       = '0;
        wvalid_nxt     = '0;
        out_strobe_nxt = 1'b1;
      end
      DP_EMIT_ZERO: out_strobe_nxt = 1'b1;
      DP_EMIT_OOW: begin
        out_strobe_nxt        = 1'b1;
        out_nxt.out_of_window = 1'b1;
      end
      DP_ADD_RD: begin
        bm_re        = 1'b1;
        acc_re       = 1'b1;
        rd_valid_nxt = wvalid_r[delta_word];
      end
      DP_ADD_WR: begin
        bm_we                  = 1'b1;
        bm_wdata               = word_eff | (WORD_BITS'(1) << delta_bit);
        wvalid_nxt[delta_word] = 1'b1;
        acc_we                 = en_r || !bit_set;
        acc_wdata              = en_r ? acc_sat : '0;
        out_strobe_nxt         = 1'b1;
      end
      DP_SCAN_RD: begin
        bm_re        = 1'b1;
        bm_raddr     = scan_idx;
        rd_valid_nxt = wvalid_r[scan_idx];
      end
      DP_SCAN_ADV: scan_nxt = scan_r + SCAN_W'(1);
      DP_TAKE_RD: begin
        bm_we     = 1'b1;
        bm_waddr  = scan_idx;
        bm_wdata  = word_eff & ~(WORD_BITS'(1) << take_bit);
        acc_re    = 1'b1;
        acc_raddr = take_slot;
      end
      DP_TAKE_OUT: begin
        out_strobe_nxt    = 1'b1;
        out_nxt.found     = 1'b1;
        out_nxt.doc_out   = base_r + 32'(slot_r);
        out_nxt.score_out = en_r ? score_clip : '0;
      end
      DP_SKIP_ALL: begin
        wvalid_nxt     = '0;
        scan_nxt       = SCAN_W'(WINDOW_WORDS);
        out_strobe_nxt = 1'b1;
      end
      DP_SKIP_RD: begin
        bm_re        = 1'b1;
        rd_valid_nxt = wvalid_r[delta_word];
        for (int i = 0; i < WINDOW_WORDS; i++) begin
          if (SCAN_W'(i) < delta_word_ext) wvalid_nxt[i] = 1'b0;
        end
        if (scan_r < delta_word_ext) scan_nxt = delta_word_ext;
      end
      DP_SKIP_WR: begin
        bm_we                  = 1'b1;
        bm_wdata               = word_eff & ({WORD_BITS{1'b1}} << delta_bit);
        wvalid_nxt[delta_word] = 1'b1;
        out_strobe_nxt         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      scan_r       <= '0;
      wvalid_r     <= '0;
      en_r         <= 1'b1;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      base_r       <= base_nxt;
      scan_r       <= scan_nxt;
      wvalid_r     <= wvalid_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_r <= in_item.command;
      doc_r     <= in_item.doc_id;
      score_r   <= in_item.term_score;
    end
    if (cmd.op == DP_TAKE_RD) slot_r <= take_slot;
    out_r <= out_nxt;
  end

  wpu_ram #(.WIDTH(WORD_BITS), .DEPTH(WINDOW_WORDS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_rdata)
  );

  wpu_ram #(.WIDTH(SCORE_BITS), .DEPTH(SLOTS)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  `WPU_ASSERT_ALWAYS(a_scan_range, clk, rst_n, scan_r <= SCAN_W'(WINDOW_WORDS), "scan past window")
  `WPU_ASSERT(a_found_excl, clk, rst_n, out_strobe_r |-> !(out_r.found && out_r.out_of_window), "found with out of window")
  `WPU_ASSERT(a_oow_flag, clk, rst_n, (cmd.op == DP_EMIT_OOW) |=> (out_strobe_r && out_r.out_of_window), "rejected add not flagged")

endmodule

// File: sv/windowed_posting_union.sv
// open, rejected add and trivial skip finish in the dispatch state, stored add and partial skip
//   add a write state, next reads bitmap words from the scan pointer until a set bit or window end
// throughput: a new item is taken the cycle its result shows; rate set by the bitmap ram scan
// the receiver cannot stall: each result is held on out_item for one cycle with out_strobe
// reset (rst_n low, synchronous) empties the window via per-word valid bits, no clearing pass
// depends on wpu_pkg, wpu_ctrl, wpu_dp and wpu_ram
module windowed_posting_union #(
  parameter int WINDOW_WORDS = 64,
  parameter int SCORE_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  wpu_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output wpu_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import wpu_pkg::*;

  // command from sequencer to datapath, status back
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: one state per ram access step of an item
  wpu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .status(status), .cmd(cmd)
  );

  // datapath: window base, scan pointer, bitmap and accumulator rams
  wpu_dp #(.WINDOW_WORDS(WINDOW_WORDS), .SCORE_BITS(SCORE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .status(status),
    .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule
